// ===== rtl/block_transposition_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// Block transposition cipher: assertion macros
// Shared property wrappers for the checker, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSPOSITION_CIPHER_DEFINES_SVH
`define BLOCK_TRANSPOSITION_CIPHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block transposition cipher package
// Field widths, register codes and the padding byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 5;
    localparam int KEY_LEN_W   = 4;
    localparam int KEY_CODES_W = 50;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0]      PAD_BYTE        = 8'h2A;
    localparam logic [KEY_LEN_W-1:0]   KEY_LEN_RESET   = 4'd2;
    localparam logic [KEY_LEN_W-1:0]   KEY_LEN_MIN     = 4'd2;
    localparam logic [KEY_CODES_W-1:0] KEY_CODES_RESET = 50'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 1'b0,
        REG_KEY_CODES  = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/block_transposition_cipher.sv =====
// ----------------------------------------------------------------------------
// Block transposition cipher
// Collects message bytes into key-length blocks in a two-bank buffer memory
// and streams each block out in key-rank order, padding a short final block.
// ----------------------------------------------------------------------------
// After the request that completes a block, its bank flag is registered;
// the first byte then passes through the memory read and output stages.
// Throughput: one byte per cycle on each side while the write bank is free
// and m_tready is high; one bank emits a block while the other collects.
// A padded final block of n bytes stalls input once both banks are in use.
// Reset clears the key to its default "AB", the fill count and all bank flags.
`timescale 1ns / 1ps
`default_nettype none

module block_transposition_cipher
    import btc_pkg::*;
#(
    parameter int MAX_KEY_LEN = 10
)(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [BYTE_W-1:0]      s_tdata,   // [7:0] in_byte
    input  wire                    s_tlast,   // end_of_message
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                   m_tlast,   // last_of_message
    input  wire                    cfg_we,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [KEY_CODES_W-1:0] cfg_wdata
);

    localparam int IDX_W       = $clog2(MAX_KEY_LEN);
    localparam int CNT_W       = $clog2(MAX_KEY_LEN + 1);
    localparam int CODES_ALL_W = CODE_W * MAX_KEY_LEN;

    // Configuration registers
    logic [KEY_LEN_W-1:0]   key_length_reg;
    logic [KEY_CODES_W-1:0] key_codes_reg;

    // Collection side
    logic             wr_bank_reg, wr_bank_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       bank_full_reg, bank_full_next;
    logic [CNT_W-1:0] desc_fill_reg [2];
    logic             desc_end_reg  [2];

    // Emission side
    logic             rd_bank_reg, rd_bank_next;
    logic [IDX_W-1:0] rd_j_reg, rd_j_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pad_reg;
    logic             s1_last_reg;
    logic [BYTE_W-1:0] mem_q_reg;
    logic             out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic [BYTE_W-1:0] mem [2][MAX_KEY_LEN];

    logic [CODES_ALL_W-1:0] codes_all;
    logic [CODE_W-1:0]      code [MAX_KEY_LEN];
    logic [CODE_W-1:0]      code_j;
    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       rank;
    logic [CNT_W-1:0]       fill_inc;
    logic                   in_acc, do_write, blk_done;
    logic                   active, issue, s1_move, last_j, pad;

    // Letters beyond the 50-bit key register read as code zero.
    generate
        if (CODES_ALL_W >= KEY_CODES_W) begin : g_codes_ext
            assign codes_all = CODES_ALL_W'(key_codes_reg);
        end
        else begin : g_codes_cut
            assign codes_all = key_codes_reg[CODES_ALL_W-1:0];
        end
        for (genvar gi = 0; gi < MAX_KEY_LEN; gi++) begin : g_code
            assign code[gi] = codes_all[gi*CODE_W +: CODE_W];
        end
    endgenerate

    always_comb
    begin
        if (key_length_reg < KEY_LEN_MIN)
        begin
            n_eff = CNT_W'(KEY_LEN_MIN);
        end
        else if (key_length_reg > KEY_LEN_W'(MAX_KEY_LEN))
        begin
            n_eff = CNT_W'(MAX_KEY_LEN);
        end
        else
        begin
            n_eff = CNT_W'(key_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_RESET;
            key_codes_reg  <= KEY_CODES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_LENGTH: key_length_reg <= cfg_wdata[KEY_LEN_W-1:0];
                REG_KEY_CODES:  key_codes_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Collection: write each byte into the current bank.
    // ------------------------------------------------------------------
    assign s_tready = !bank_full_reg[wr_bank_reg];
    assign in_acc   = s_tvalid && s_tready;
    assign do_write = in_acc && (fill_reg < CNT_W'(MAX_KEY_LEN));
    assign fill_inc = do_write ? fill_reg + CNT_W'(1) : fill_reg;
    assign blk_done = in_acc && ((fill_inc >= n_eff) || s_tlast);

    // ------------------------------------------------------------------
    // Emission: rank of letter j selects the buffered byte to read.
    // ------------------------------------------------------------------
    assign active = bank_full_reg[rd_bank_reg];
    assign code_j = code[rd_j_reg];

    always_comb
    begin
        rank = '0;
        for (int i = 0; i < MAX_KEY_LEN; i++)
        begin
            if ((CNT_W'(i) < n_eff) && (code[i] < code_j))
            begin
                rank = rank + CNT_W'(1);
            end
        end
    end

    assign pad     = rank >= desc_fill_reg[rd_bank_reg];
    assign last_j  = CNT_W'(rd_j_reg) == (n_eff - CNT_W'(1));
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_tready);
    assign issue   = active && (!s1_valid_reg || s1_move);

    always_comb
    begin
        wr_bank_next   = wr_bank_reg;
        fill_next      = fill_reg;
        bank_full_next = bank_full_reg;
        rd_bank_next   = rd_bank_reg;
        rd_j_next      = rd_j_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (in_acc)
        begin
            fill_next = fill_inc;
        end
        if (blk_done)
        begin
            fill_next                   = '0;
            bank_full_next[wr_bank_reg] = 1'b1;
            wr_bank_next                = !wr_bank_reg;
        end

        // A bank that is filling is never the one being drained, so the two
        // flag updates below always touch different banks.
        if (issue)
        begin
            if (last_j)
            begin
                rd_j_next                   = '0;
                bank_full_next[rd_bank_reg] = 1'b0;
                rd_bank_next                = !rd_bank_reg;
            end
            else
            begin
                rd_j_next = rd_j_reg + IDX_W'(1);
            end
        end

        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_bank_reg   <= 1'b0;
            fill_reg      <= '0;
            bank_full_reg <= '0;
            rd_bank_reg   <= 1'b0;
            rd_j_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_bank_reg   <= wr_bank_next;
            fill_reg      <= fill_next;
            bank_full_reg <= bank_full_next;
            rd_bank_reg   <= rd_bank_next;
            rd_j_reg      <= rd_j_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Block descriptors, read stage and output payload.
    always_ff @(posedge clk)
    begin
        if (blk_done)
        begin
            desc_fill_reg[wr_bank_reg] <= fill_inc;
            desc_end_reg[wr_bank_reg]  <= s_tlast;
        end
        if (issue)
        begin
            s1_pad_reg  <= pad;
            s1_last_reg <= desc_end_reg[rd_bank_reg] && last_j;
        end
        if (s1_move)
        begin
            out_data_reg <= s1_pad_reg ? PAD_BYTE : mem_q_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    // Block buffer: one write port for collection, one read port for emission.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_bank_reg][fill_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (issue)
        begin
            mem_q_reg <= mem[rd_bank_reg][rank[IDX_W-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/btc_checker.sv =====
// ----------------------------------------------------------------------------
// Block transposition cipher checker
// Port-level properties of the cipher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "block_transposition_cipher_defines.svh"

module btc_checker
    import btc_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              s_tvalid,
    input wire              s_tready,
    input wire              s_tlast,
    input wire              m_tvalid,
    input wire              m_tready,
    input wire [BYTE_W-1:0] m_tdata,
    input wire              m_tlast
);

    // A stalled output byte must stay on the bus unchanged.
    `BTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output request changed while stalled")

    // Nothing is offered straight out of reset.
    `BTC_ASSERT_SAME(a_reset_idle, $rose(rst_n), !m_tvalid, "output valid straight after reset")

    // The end of a message always closes a block, so output must be offered soon after.
    `BTC_ASSERT_NEXT(a_end_flush, s_tvalid && s_tready && s_tlast, ##2 m_tvalid, "final block not emitted")

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (.*);

`default_nettype wire

// ===== dv/block_transposition_cipher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block transposition cipher testbench
// Drives message bytes into the cipher, with key register writes between
// bytes. A behavioural model of the cipher predicts every ciphertext byte,
// and each one received is checked against the oldest prediction. Short
// directed script first, then random messages under varying back-pressure.
// ----------------------------------------------------------------------------

module block_transposition_cipher_test;
    import btc_pkg::*;

    localparam int MAX_KEY_LEN      = 10;
    localparam int DRAIN_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 24;

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              last;
    } cipher_byte_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        cfg_reg_t                sel;
        logic [KEY_CODES_W-1:0]  value;
        logic [BYTE_W-1:0]       text;
        logic                    eom;
        logic                    known;
        logic [1:0][BYTE_W-1:0]  pair;   // pair[0] is the first byte out
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;     // [7:0] in_byte
    logic                   s_tlast;     // end_of_message
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;     // [7:0] out_byte
    logic                   m_tlast;     // last_of_message
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [KEY_CODES_W-1:0] cfg_wdata;

    // Model state of the cipher.
    logic [KEY_LEN_W-1:0]   key_len_reg;
    logic [KEY_CODES_W-1:0] key_codes_reg;
    logic [BYTE_W-1:0]      held [MAX_KEY_LEN];
    int                     held_cnt;

    cipher_byte_t cipher_q [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           src_gap_pct = 0;
    int           dst_gap_pct = 0;
    script_row_t  script [$];

    block_transposition_cipher #(
        .MAX_KEY_LEN(MAX_KEY_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int block_size();
        int n;
        n = key_len_reg;
        if (n < 2) n = 2;
        if (n > MAX_KEY_LEN) n = MAX_KEY_LEN;
        return n;
    endfunction

    // Rank of a key letter: how many letters of the key have a strictly smaller code.
    function automatic int letter_rank(int j, int n);
        int r;
        r = 0;
        for (int i = 0; i < n; i++)
        begin
            if (key_codes_reg[5*i +: 5] < key_codes_reg[5*j +: 5]) r++;
        end
        return r;
    endfunction

    function automatic int encipher(input logic [BYTE_W-1:0] text, input logic eom,
                                    output cipher_byte_t blk [MAX_KEY_LEN]);
        int n;
        int r;
        n = block_size();
        if (held_cnt < MAX_KEY_LEN)
        begin
            held[held_cnt] = text;
            held_cnt++;
        end
        if (held_cnt < n && !eom) return 0;
        // If the key was shortened mid-block, only the first n bytes are used.
        for (int j = 0; j < n; j++)
        begin
            r = letter_rank(j, n);
            blk[j].text = (r < held_cnt) ? held[r] : PAD_BYTE;
            blk[j].last = eom && (j == n - 1);
        end
        held_cnt = 0;
        return n;
    endfunction

    function automatic script_row_t item_row(logic [BYTE_W-1:0] text, logic eom);
        script_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.text = text;
        row.eom = eom;
        return row;
    endfunction

    function automatic script_row_t known_row(logic [BYTE_W-1:0] text, logic eom,
                                              logic [1:0][BYTE_W-1:0] pair);
        script_row_t row;
        row = item_row(text, eom);
        row.known = 1'b1;
        row.pair = pair;
        return row;
    endfunction

    function automatic script_row_t write_row(cfg_reg_t sel, logic [KEY_CODES_W-1:0] value);
        script_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.sel = sel;
        row.value = value;
        return row;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] text, input logic eom,
                             input logic known, input logic [1:0][BYTE_W-1:0] pair);
        cipher_byte_t blk [MAX_KEY_LEN];
        int n;
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text;
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
        n = encipher(text, eom, blk);
        for (int j = 0; j < n; j++)
        begin
            if (known) blk[j].text = pair[j];
            cipher_q.push_back(blk[j]);
        end
    endtask

    // Waits until every predicted byte has been received and the pipeline is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_reg(input cfg_reg_t sel, input logic [KEY_CODES_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_KEY_LENGTH)
            key_len_reg = value[KEY_LEN_W-1:0];
        else
            key_codes_reg = value;
    endtask

    task automatic rekey();
        logic [KEY_CODES_W-1:0] codes;
        logic [25:0]            used;
        logic [4:0]             c;
        codes = {18'($urandom), 32'($urandom)};
        used = '0;
        // Mostly a key of distinct letters; otherwise raw codes with ties and 26..31.
        if ($urandom_range(3) != 0)
        begin
            for (int i = 0; i < MAX_KEY_LEN; i++)
            begin
                do c = 5'($urandom_range(25)); while (used[c]);
                used[c] = 1'b1;
                codes[5*i +: 5] = c;
            end
        end
        if ($urandom_range(4) == 0)
            write_key_reg(REG_KEY_LENGTH, KEY_CODES_W'($urandom_range(15)));
        else
            write_key_reg(REG_KEY_LENGTH, KEY_CODES_W'($urandom_range(2, MAX_KEY_LEN)));
        write_key_reg(REG_KEY_CODES, codes);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected byte %02h last %0b", m_tdata, m_tlast);
            end
            else
            begin
                if (m_tdata !== cipher_q[0].text || m_tlast !== cipher_q[0].last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("expected byte %02h last %0b, got byte %02h last %0b",
                                 cipher_q[0].text, cipher_q[0].last, m_tdata, m_tlast);
                end
                void'(cipher_q.pop_front());
            end
        end
        m_tready <= rst_n && ($urandom_range(99) >= dst_gap_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int msg_len;
        logic eom;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_KEY_LENGTH;
        cfg_wdata <= '0;
        key_len_reg   = KEY_LEN_RESET;
        key_codes_reg = KEY_CODES_RESET;
        held_cnt      = 0;

        script = '{
            item_row(8'h00, 1'b0),
            // Reset key AB keeps the pair in order.
            known_row(8'hFF, 1'b0, {8'hFF, 8'h00}),
            known_row(8'h41, 1'b1, {PAD_BYTE, 8'h41}),
            // Key BA swaps each pair.
            write_row(REG_KEY_CODES, 50'd1),
            item_row(8'hFF, 1'b0),
            known_row(8'h00, 1'b1, {8'hFF, 8'h00}),
            // Length above the maximum, every letter tied at code 31.
            write_row(REG_KEY_LENGTH, 50'd15),
            write_row(REG_KEY_CODES, {KEY_CODES_W{1'b1}}),
            item_row(8'h80, 1'b0),
            item_row(8'h7F, 1'b0),
            item_row(8'h01, 1'b0),
            item_row(8'hFE, 1'b0),
            item_row(8'h55, 1'b0),
            item_row(8'hAA, 1'b1),
            // Mixed codes including 26..31, then the key shortened mid-block.
            write_row(REG_KEY_LENGTH, 50'd10),
            write_row(REG_KEY_CODES, 50'h3_7E8C_B15A_4D29),
            item_row(8'h11, 1'b0),
            item_row(8'h22, 1'b0),
            item_row(8'h33, 1'b0),
            item_row(8'h44, 1'b0),
            write_row(REG_KEY_LENGTH, 50'd3),
            item_row(8'h55, 1'b0),
            // Length below the minimum with an all-zero key.
            write_row(REG_KEY_LENGTH, 50'd1),
            write_row(REG_KEY_CODES, 50'd0),
            item_row(8'h66, 1'b0),
            item_row(8'h77, 1'b0),
            write_row(REG_KEY_LENGTH, 50'd0),
            known_row(8'h88, 1'b1, {8'h88, 8'h88}),
            write_row(REG_KEY_LENGTH, KEY_CODES_W'(KEY_LEN_RESET)),
            write_row(REG_KEY_CODES, KEY_CODES_RESET)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gap_pct = 35;
        dst_gap_pct = 83;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_key_reg(script[i].sel, script[i].value);
            else
                send_byte(script[i].text, script[i].eom, script[i].known, script[i].pair);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_gap_pct = (ph == 0) ? 35 : (ph == 1) ? 83 : 0;
            dst_gap_pct = (ph == 0) ? 83 : (ph == 1) ? 35 : 0;
            rekey();
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(3) == 0) rekey();
                msg_len = $urandom_range(1, 20);
                for (int k = 0; k < msg_len; k++)
                begin
                    // Now and then a message runs on into the next without its end mark.
                    eom = (k == msg_len - 1) && ($urandom_range(6) != 0);
                    send_byte(8'($urandom_range(255)), eom, 1'b0, '0);
                end
                sent += msg_len;
            end
        end

        settle();
        repeat (20) @(posedge clk);
        mismatch_count += cipher_q.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/btc_pkg.sv
rtl/block_transposition_cipher.sv
rtl/btc_checker.sv
dv/block_transposition_cipher_test.sv
